/* design/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the LRU key/value cache
// Operation codes, cell control struct and the fixed field widths.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KIND_W = 3;
  localparam int CAP_W  = 5;
  localparam int OCC_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 3'd0,
    KIND_PEEK   = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  // What a cell loads at the update edge.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_FRONT = 2'd1,
    CELL_PREV  = 2'd2,
    CELL_NEXT  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     cmp_en;
  } cell_ctrl_t;

endpackage

/* design/lkv_cell.sv */
// ----------------------------------------------------------------------------
// lkv_cell: one recency position of the LRU cache
// Holds one key/value pair, compares its key and shifts to or from neighbors.
// ----------------------------------------------------------------------------
module lkv_cell #(
  parameter int KEY_WIDTH  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  lkv_pkg::cell_ctrl_t   ctrl_i,
  input  logic [KEY_WIDTH-1:0]  cmp_key_i,
  input  logic [KEY_WIDTH-1:0]  front_key_i,
  input  logic [DATA_WIDTH-1:0] front_data_i,
  input  logic [KEY_WIDTH-1:0]  prev_key_i,
  input  logic [DATA_WIDTH-1:0] prev_data_i,
  input  logic [KEY_WIDTH-1:0]  next_key_i,
  input  logic [DATA_WIDTH-1:0] next_data_i,
  output logic [KEY_WIDTH-1:0]  key_o,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  match_o
);

  logic [KEY_WIDTH-1:0]  key_q, key_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    key_d  = key_q;
    data_d = data_q;
    case (ctrl_i.op)
      lkv_pkg::CELL_FRONT: begin
        key_d  = front_key_i;
        data_d = front_data_i;
      end
      lkv_pkg::CELL_PREV: begin
        key_d  = prev_key_i;
        data_d = prev_data_i;
      end
      lkv_pkg::CELL_NEXT: begin
        key_d  = next_key_i;
        data_d = next_data_i;
      end
      default: begin
        key_d  = key_q;
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
  end

  assign key_o   = key_q;
  assign data_o  = data_q;
  assign match_o = ctrl_i.cmp_en && (key_q == cmp_key_i);

endmodule

/* design/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache with LRU replacement
// Entries sit in a row of cells ordered by recency, most recent in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   An operation (kind_i, key_i, write_data_i) is taken at a rising edge with
//   start_i high and busy_o low. Kinds are lookup, peek, insert, remove and
//   clear. Each operation gives one result beat on hit_o, read_data_o and
//   occupancy_o, marked by result_valid_o for exactly one cycle; the receiver
//   cannot stall it.
//   Timing: the edge that takes an operation is followed by a compare cycle
//   (all cells check the key in parallel) and an update cycle (the row of
//   cells shifts by one position around the hit cell). The result beat shows
//   in the cycle after the update, when busy_o is already low, so a new
//   operation can be taken at the edge that ends the result beat.
//   Capacity is written through capacity_we_i/capacity_i only while
//   the block is idle; the user must keep to this, as the block itself does
//   not enforce it. Zero acts as one and values above DEPTH act as DEPTH;
//   a lowered capacity trims the oldest entries at the next insert.
//   Reset empties the cache and sets the capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int DEPTH      = 16,
  parameter int KEY_WIDTH  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [lkv_pkg::KIND_W-1:0]   kind_i,
  input  logic [KEY_WIDTH-1:0]         key_i,
  input  logic [DATA_WIDTH-1:0]        write_data_i,
  input  logic                         capacity_we_i,
  input  logic [lkv_pkg::CAP_W-1:0]    capacity_i,
  output logic                         result_valid_o,
  output logic                         hit_o,
  output logic [DATA_WIDTH-1:0]        read_data_o,
  output logic [lkv_pkg::OCC_W-1:0]    occupancy_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > lkv_pkg::OCC_W) ? CW : lkv_pkg::OCC_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_UPD  = 2'd2
  } state_e;

  state_e state_q;

  logic [lkv_pkg::CAP_W-1:0] cap_q;
  logic [CW-1:0]             count_q, count_d;
  logic                      res_valid_q, res_hit_q;
  logic [DATA_WIDTH-1:0]     res_data_q;
  logic [lkv_pkg::OCC_W-1:0] res_occ_q;

  lkv_pkg::kind_e            op_kind_q;
  logic [KEY_WIDTH-1:0]      op_key_q;
  logic [DATA_WIDTH-1:0]     op_data_q;
  logic [DEPTH-1:0]          match_q;
  logic                      hit_q;
  logic [DATA_WIDTH-1:0]     hit_data_q;

  logic [KEY_WIDTH-1:0]      cell_key  [DEPTH];
  logic [DATA_WIDTH-1:0]     cell_data [DEPTH];
  logic [DEPTH-1:0]          cell_match;
  logic [DEPTH-1:0]          cell_valid;
  logic [DEPTH-1:0]          at_or_after;
  logic [DEPTH-1:0]          at_or_before;
  lkv_pkg::cell_ctrl_t       cell_ctrl [DEPTH];

  logic [DATA_WIDTH-1:0]     hit_data_d;
  logic [DATA_WIDTH-1:0]     front_data;
  logic [MW-1:0]             cap_raw, cap_eff, cnt_ext, keep_hit, keep_miss;
  logic                      res_hit_d;
  logic [DATA_WIDTH-1:0]     res_data_d;

  // --------------------------------------------------------------------------
  // Row of cells
  // --------------------------------------------------------------------------
  assign front_data = (op_kind_q == lkv_pkg::KIND_INSERT) ? op_data_q : hit_data_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_WIDTH-1:0]  prev_key, next_key;
    logic [DATA_WIDTH-1:0] prev_data, next_data;

    assign cell_valid[g]   = (CW'(g) < count_q);
    assign at_or_after[g]  = |match_q[DEPTH-1:g];
    assign at_or_before[g] = |match_q[g:0];

    if (g == 0) begin : g_first
      assign prev_key  = op_key_q;
      assign prev_data = front_data;
    end else begin : g_mid
      assign prev_key  = cell_key[g-1];
      assign prev_data = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_key  = cell_key[g];
      assign next_data = cell_data[g];
    end else begin : g_body
      assign next_key  = cell_key[g+1];
      assign next_data = cell_data[g+1];
    end

    // A hit cell moves to the front and the younger ones slide back one place;
    // a removal closes the gap by pulling older entries forward.
    always_comb begin
      cell_ctrl[g].op     = lkv_pkg::CELL_HOLD;
      cell_ctrl[g].cmp_en = cell_valid[g];
      if (state_q == ST_UPD) begin
        case (op_kind_q)
          lkv_pkg::KIND_LOOKUP: begin
            if (hit_q) begin
              if (g == 0) cell_ctrl[g].op = lkv_pkg::CELL_FRONT;
              else if (at_or_after[g]) cell_ctrl[g].op = lkv_pkg::CELL_PREV;
            end
          end
          lkv_pkg::KIND_INSERT: begin
            if (g == 0) cell_ctrl[g].op = lkv_pkg::CELL_FRONT;
            else if (!hit_q || at_or_after[g]) cell_ctrl[g].op = lkv_pkg::CELL_PREV;
          end
          lkv_pkg::KIND_REMOVE: begin
            if (hit_q && at_or_before[g] && (g < DEPTH - 1)) begin
              cell_ctrl[g].op = lkv_pkg::CELL_NEXT;
            end
          end
          default: cell_ctrl[g].op = lkv_pkg::CELL_HOLD;
        endcase
      end
    end

    lkv_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[g]),
      .cmp_key_i   (op_key_q),
      .front_key_i (op_key_q),
      .front_data_i(front_data),
      .prev_key_i  (prev_key),
      .prev_data_i (prev_data),
      .next_key_i  (next_key),
      .next_data_i (next_data),
      .key_o       (cell_key[g]),
      .data_o      (cell_data[g]),
      .match_o     (cell_match[g])
    );
  end

  // Only one valid cell can match, so an AND-OR picks its data.
  always_comb begin
    hit_data_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_match[i]) hit_data_d = hit_data_d | cell_data[i];
    end
  end

  // --------------------------------------------------------------------------
  // Occupancy
  // --------------------------------------------------------------------------
  always_comb begin
    cap_raw = MW'(cap_q);
    cap_eff = cap_raw;
    if (cap_raw == '0) cap_eff = MW'(1);
    else if (cap_raw > MW'(DEPTH)) cap_eff = MW'(DEPTH);
    cnt_ext   = MW'(count_q);
    keep_hit  = (cnt_ext > cap_eff) ? cap_eff : cnt_ext;
    keep_miss = ((cnt_ext > cap_eff - MW'(1)) ? cap_eff - MW'(1) : cnt_ext) + MW'(1);
  end

  always_comb begin
    count_d    = count_q;
    res_hit_d  = 1'b0;
    res_data_d = '0;
    case (op_kind_q)
      lkv_pkg::KIND_LOOKUP, lkv_pkg::KIND_PEEK: begin
        res_hit_d = hit_q;
        if (hit_q) res_data_d = hit_data_q;
      end
      lkv_pkg::KIND_INSERT: begin
        res_hit_d = hit_q;
        count_d   = hit_q ? CW'(keep_hit) : CW'(keep_miss);
      end
      lkv_pkg::KIND_REMOVE: begin
        res_hit_d = hit_q;
        if (hit_q) count_d = count_q - CW'(1);
      end
      lkv_pkg::KIND_CLEAR: count_d = '0;
      default: count_d = count_q;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer, occupancy and result beat
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= lkv_pkg::CAP_RESET;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      res_hit_q   <= 1'b0;
      res_data_q  <= '0;
      res_occ_q   <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (capacity_we_i) cap_q <= capacity_i;
      case (state_q)
        ST_IDLE: begin
          if (start_i) state_q <= ST_CMP;
        end
        ST_CMP: state_q <= ST_UPD;
        ST_UPD: begin
          state_q     <= ST_IDLE;
          count_q     <= count_d;
          res_valid_q <= 1'b1;
          res_hit_q   <= res_hit_d;
          res_data_q  <= res_data_d;
          res_occ_q   <= lkv_pkg::OCC_W'(count_d);
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      op_kind_q <= lkv_pkg::kind_e'(kind_i);
      op_key_q  <= key_i;
      op_data_q <= write_data_i;
    end
    if (state_q == ST_CMP) begin
      match_q    <= cell_match;
      hit_q      <= |cell_match;
      hit_data_q <= hit_data_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign hit_o          = res_hit_q;
  assign read_data_o    = res_data_q;
  assign occupancy_o    = res_occ_q;

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond the number of cells");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> $onehot0(match_q))
    else $error("key found in more than one cell");

  a_take_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o ##1 busy_o ##1 (result_valid_o && !busy_o))
    else $error("result beat not two cycles after the busy period opened");

  a_insert_occupies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && op_kind_q == lkv_pkg::KIND_INSERT) |=> (occupancy_o != '0))
    else $error("insert left the cache empty");
`endif

endmodule
